// ----- rtl/core/tsac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsac_pkg
// Types and constants for the touch sample averaging and calibration block.
// ----------------------------------------------------------------------------
package tsac_pkg;

  localparam int FRAME_W   = 16;
  localparam int READING_W = 12;
  localparam int SUM_W     = 16;
  localparam int COUNT_W   = 5;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = COEF_W + READING_W + 1;
  localparam int NUM_W     = PROD_W + 1;
  localparam int QUOT_W    = NUM_W + 1;
  localparam int PIX_W     = 11;
  localparam int STATUS_W  = 2;
  localparam int ORIENT_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 6;

  localparam logic [READING_W-1:0] READING_MAX = 12'd4095;
  localparam logic [CNT_W-1:0]     DIV_STEPS   = 6'd46;
  localparam logic [PIX_W-1:0]     PIX_NONE    = 11'h7FF;

  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR     = 3'd7;

  localparam logic [ORIENT_W-1:0] ORIENT_0   = 2'd0;
  localparam logic [ORIENT_W-1:0] ORIENT_90  = 2'd1;
  localparam logic [ORIENT_W-1:0] ORIENT_180 = 2'd2;
  localparam logic [ORIENT_W-1:0] ORIENT_270 = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_PEN_UP = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_VALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;

  localparam logic [COEF_W-1:0] RST_COEF_A  = 32'h000066F0;
  localparam logic [COEF_W-1:0] RST_COEF_B  = 32'h00041F40;
  localparam logic [COEF_W-1:0] RST_COEF_C  = 32'hBD1B79BC;
  localparam logic [COEF_W-1:0] RST_COEF_D  = 32'h0005ACC6;
  localparam logic [COEF_W-1:0] RST_COEF_E  = 32'h00001CCA;
  localparam logic [COEF_W-1:0] RST_COEF_F  = 32'hA7450C8A;
  localparam logic [COEF_W-1:0] RST_DIVISOR = 32'hFFBF9A56;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic mul_term;
    logic acc_init;
    logic acc_add;
    logic axis;
    logic div_load;
    logic div_step;
    logic q_store;
    logic out_load;
    logic out_pen;
  } cmd_t;

  typedef struct packed {
    logic pen_up;
    logic final_pair;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/touch_sample_average_calibrate.sv -----
`default_nettype none
// Result path: a pen-up request goes from acceptance to the hand-off state
// and then to the output register; a final pair first runs the multiply-add
// steps and the one-bit-per-cycle divider for each axis, then the hand-off.
// Throughput: one request per cycle for reference and intermediate pairs;
// input stalls after a pen-up or a final pair until its result is handed off.
// Reset (rst, synchronous): configuration to defaults, collection empty.
// ----------------------------------------------------------------------------
// touch_sample_average_calibrate
// Touch sample averaging with three-point affine calibration and rotation.
// ----------------------------------------------------------------------------
module touch_sample_average_calibrate
  import tsac_pkg::*;
#(
  parameter int PANEL_WIDTH   = 240,
  parameter int PANEL_HEIGHT  = 320,
  parameter int AVERAGE_COUNT = 16,
  parameter int MAX_DEVIATION = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 pen_up,
  input  wire logic [FRAME_W-1:0]   first_frame,
  input  wire logic [FRAME_W-1:0]   second_frame,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [PIX_W-1:0]   touch_x,
  output logic signed [PIX_W-1:0]   touch_y,
  output logic [STATUS_W-1:0]       status
);

  cmd_t    cmd;
  status_t sts;

  tsac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsac_datapath #(
    .PANEL_WIDTH   (PANEL_WIDTH),
    .PANEL_HEIGHT  (PANEL_HEIGHT),
    .AVERAGE_COUNT (AVERAGE_COUNT),
    .MAX_DEVIATION (MAX_DEVIATION)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pen_up       (pen_up),
    .first_frame  (first_frame),
    .second_frame (second_frame),
    .cmd          (cmd),
    .sts          (sts),
    .touch_x      (touch_x),
    .touch_y      (touch_y),
    .status       (status)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tsac_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsac_ctrl
// Sequencer: request intake, multiply-accumulate steps, divider steps and
// result hand-off.
// ----------------------------------------------------------------------------
module tsac_ctrl
  import tsac_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             axis, axis_next;
  logic             pen_res, pen_res_next;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cnt_next     = cnt;
    axis_next    = axis;
    pen_res_next = pen_res;
    in_stall     = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.pen_up) begin
            pen_res_next = 1'b1;
            state_next   = ST_EMIT;
          end else if (sts.final_pair) begin
            pen_res_next = 1'b0;
            axis_next    = 1'b0;
            cnt_next     = '0;
            state_next   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (cnt == '0) begin
          cmd.mul_en   = 1'b1;
          cmd.acc_init = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else if (cnt == CNT_W'(1)) begin
          cmd.mul_en   = 1'b1;
          cmd.mul_term = 1'b1;
          cmd.acc_add  = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else begin
          cmd.acc_add = 1'b1;
          cnt_next    = '0;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          cmd.div_load = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else if (cnt <= DIV_STEPS) begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else begin
          cmd.q_store = 1'b1;
          cnt_next    = '0;
          if (!axis) begin
            axis_next  = 1'b1;
            state_next = ST_MUL;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.axis    = axis;
    cmd.out_pen = pen_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      axis      <= 1'b0;
      pen_res   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      axis    <= axis_next;
      pen_res <= pen_res_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tsac_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsac_datapath
// Sample conditioning, averaging, calibration multiply-accumulate, shared
// restoring divider, range check, rotation and output registers.
// ----------------------------------------------------------------------------
module tsac_datapath
  import tsac_pkg::*;
#(
  parameter int PANEL_WIDTH   = 240,
  parameter int PANEL_HEIGHT  = 320,
  parameter int AVERAGE_COUNT = 16,
  parameter int MAX_DEVIATION = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  input  wire logic                 pen_up,
  input  wire logic [FRAME_W-1:0]   first_frame,
  input  wire logic [FRAME_W-1:0]   second_frame,
  input  wire cmd_t                 cmd,
  output status_t                   sts,
  output logic signed [PIX_W-1:0]   touch_x,
  output logic signed [PIX_W-1:0]   touch_y,
  output logic [STATUS_W-1:0]       status
);

  logic [ORIENT_W-1:0] orientation;
  logic [COEF_W-1:0]   coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= ORIENT_0;
      coef_a      <= RST_COEF_A;
      coef_b      <= RST_COEF_B;
      coef_c      <= RST_COEF_C;
      coef_d      <= RST_COEF_D;
      coef_e      <= RST_COEF_E;
      coef_f      <= RST_COEF_F;
      divisor     <= RST_DIVISOR;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ORIENTATION: orientation <= cfg_data[ORIENT_W-1:0];
        REG_COEF_A:      coef_a      <= cfg_data;
        REG_COEF_B:      coef_b      <= cfg_data;
        REG_COEF_C:      coef_c      <= cfg_data;
        REG_COEF_D:      coef_d      <= cfg_data;
        REG_COEF_E:      coef_e      <= cfg_data;
        REG_COEF_F:      coef_f      <= cfg_data;
        REG_DIVISOR:     divisor     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample conditioning and collection
  // average by reciprocal multiply, exact for any 16-bit sum and count up to 16
  localparam int AVG_SHIFT  = 20;
  localparam int AVG_PROD_W = SUM_W + AVG_SHIFT;
  localparam logic [AVG_SHIFT-1:0] AVG_RECIP =
    AVG_SHIFT'((2 ** AVG_SHIFT + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

  logic [READING_W-1:0] rf, rs, ref_first, ref_second, dev_first, dev_second;
  logic [READING_W:0]   shift_first, shift_second;
  logic [SUM_W-1:0]     sum_first, sum_second, sum_first_next, sum_second_next;
  logic [COUNT_W-1:0]   pair_count;
  logic [READING_W-1:0] avg_x, avg_y;
  logic [AVG_PROD_W-1:0] avg_prod_x, avg_prod_y;
  logic                 deviates, last_pair;

  assign shift_first  = first_frame[FRAME_W-1:3];
  assign shift_second = second_frame[FRAME_W-1:3];
  assign rf = shift_first[READING_W]  ? READING_MAX : shift_first[READING_W-1:0];
  assign rs = shift_second[READING_W] ? READING_MAX : shift_second[READING_W-1:0];

  assign dev_first  = (rf > ref_first)  ? rf - ref_first  : ref_first - rf;
  assign dev_second = (rs > ref_second) ? rs - ref_second : ref_second - rs;
  assign deviates   = (dev_first  > READING_W'(MAX_DEVIATION)) ||
                      (dev_second > READING_W'(MAX_DEVIATION));
  assign last_pair  = pair_count >= COUNT_W'(AVERAGE_COUNT);

  assign sum_first_next  = sum_first  + SUM_W'(rf);
  assign sum_second_next = sum_second + SUM_W'(rs);

  assign avg_prod_x = AVG_PROD_W'(sum_first_next)  * AVG_PROD_W'(AVG_RECIP);
  assign avg_prod_y = AVG_PROD_W'(sum_second_next) * AVG_PROD_W'(AVG_RECIP);

  assign sts.pen_up     = pen_up;
  assign sts.final_pair = (pair_count != '0) && !deviates && last_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
    end else if (cmd.accept) begin
      if (pen_up) begin
        pair_count <= '0;
      end else if (pair_count == '0) begin
        pair_count <= COUNT_W'(1);
      end else if (deviates || last_pair) begin
        pair_count <= '0;
      end else begin
        pair_count <= pair_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !pen_up) begin
      if (pair_count == '0) begin
        ref_first  <= rf;
        ref_second <= rs;
        sum_first  <= '0;
        sum_second <= '0;
      end else begin
        sum_first  <= sum_first_next;
        sum_second <= sum_second_next;
        if (last_pair) begin
          avg_x <= avg_prod_x[AVG_SHIFT +: READING_W];
          avg_y <= avg_prod_y[AVG_SHIFT +: READING_W];
        end
      end
    end
  end

  // calibration multiply-accumulate
  logic signed [COEF_W-1:0]    mul_coef;
  logic signed [READING_W:0]   mul_op;
  logic signed [PROD_W-1:0]    prod;
  logic signed [NUM_W-1:0]     acc;
  logic [COEF_W-1:0]           offset;

  always_comb begin
    case ({cmd.axis, cmd.mul_term})
      2'b00:   mul_coef = $signed(coef_a);
      2'b01:   mul_coef = $signed(coef_b);
      2'b10:   mul_coef = $signed(coef_d);
      default: mul_coef = $signed(coef_e);
    endcase
    mul_op = $signed({1'b0, cmd.mul_term ? avg_y : avg_x});
    offset = cmd.axis ? coef_f : coef_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_coef * mul_op;
    end
    if (cmd.acc_init) begin
      acc <= NUM_W'($signed(offset));
    end else if (cmd.acc_add) begin
      acc <= acc + NUM_W'(prod);
    end
  end

  // restoring divider on magnitudes
  logic [COEF_W-1:0]   dmag, rem;
  logic [NUM_W-1:0]    qn;
  logic [COEF_W:0]     trial;
  logic                q_neg, take;
  logic signed [QUOT_W-1:0] quot;
  logic                cx_ok, cy_ok;
  logic [PIX_W-1:0]    cx, cy;

  assign dmag  = divisor[COEF_W-1] ? (~divisor + 1'b1) : divisor;
  assign trial = {rem, qn[NUM_W-1]};
  assign take  = trial >= {1'b0, dmag};
  assign quot  = q_neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem   <= '0;
      qn    <= acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
      q_neg <= acc[NUM_W-1] ^ divisor[COEF_W-1];
    end else if (cmd.div_step) begin
      rem <= take ? COEF_W'(trial - {1'b0, dmag}) : trial[COEF_W-1:0];
      qn  <= {qn[NUM_W-2:0], take};
    end
    if (cmd.q_store) begin
      if (!cmd.axis) begin
        cx    <= quot[PIX_W-1:0];
        cx_ok <= (quot > 0) && (quot < $signed(QUOT_W'(PANEL_WIDTH)));
      end else begin
        cy    <= quot[PIX_W-1:0];
        cy_ok <= (quot > 0) && (quot < $signed(QUOT_W'(PANEL_HEIGHT)));
      end
    end
  end

  // rotation and output register
  logic [PIX_W-1:0] rx, ry;

  always_comb begin
    case (orientation)
      ORIENT_90: begin
        rx = cx;
        ry = cy;
      end
      ORIENT_180: begin
        rx = cy;
        ry = PIX_W'(PANEL_HEIGHT) - cx;
      end
      ORIENT_270: begin
        rx = cx;
        ry = PIX_W'(PANEL_WIDTH) - cy;
      end
      default: begin
        rx = PIX_W'(PANEL_WIDTH) - cy;
        ry = cx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_pen) begin
        touch_x <= PIX_NONE;
        touch_y <= PIX_NONE;
        status  <= STAT_PEN_UP;
      end else if ((divisor == '0) || !cx_ok || !cy_ok) begin
        touch_x <= PIX_NONE;
        touch_y <= PIX_NONE;
        status  <= STAT_RANGE;
      end else begin
        touch_x <= rx;
        touch_y <= ry;
        status  <= STAT_VALID;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/touch_sample_average_calibrate_tb.sv -----
// ----------------------------------------------------------------------------
// touch_sample_average_calibrate_tb
// Self-checking bench for the touch averaging and calibration block. Sends
// pen-up requests, clean 17-pair touches, broken touches and noise under a
// series of calibration settings. A built-in predictor tracks the collection
// and the calibration, and every result is checked field by field.
// ----------------------------------------------------------------------------
module touch_sample_average_calibrate_tb;
  import tsac_pkg::*;

  localparam int PANEL_WIDTH    = 240;
  localparam int PANEL_HEIGHT   = 320;
  localparam int AVERAGE_COUNT  = 16;
  localparam int MAX_DEVIATION  = 100;
  localparam int BLOCK_LATENCY  = 120;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [STATUS_W-1:0]     status;
  } touch_point_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wen;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       pen_up;
  logic [FRAME_W-1:0]         first_frame;
  logic [FRAME_W-1:0]         second_frame;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [PIX_W-1:0]    touch_x;
  logic signed [PIX_W-1:0]    touch_y;
  logic [STATUS_W-1:0]        status;

  // calibration shadow
  logic [ORIENT_W-1:0] cal_orient = ORIENT_0;
  int cal_a   = RST_COEF_A;
  int cal_b   = RST_COEF_B;
  int cal_c   = RST_COEF_C;
  int cal_d   = RST_COEF_D;
  int cal_e   = RST_COEF_E;
  int cal_f   = RST_COEF_F;
  int cal_div = RST_DIVISOR;

  // collection shadow
  logic [READING_W-1:0] anchor_first  = '0;
  logic [READING_W-1:0] anchor_second = '0;
  logic [SUM_W-1:0]     acc_first     = '0;
  logic [SUM_W-1:0]     acc_second    = '0;
  int                   held_pairs    = 0;

  touch_point_t touch_q[$];
  int  mismatches  = 0;
  int  items_sent  = 0;
  int  rx_hold     = 2;
  int  idle_cycles = 0;
  bit  no_gaps     = 1'b0;

  touch_sample_average_calibrate #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .AVERAGE_COUNT(AVERAGE_COUNT),
    .MAX_DEVIATION(MAX_DEVIATION)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pen_up      (pen_up),
    .first_frame (first_frame),
    .second_frame(second_frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .touch_x     (touch_x),
    .touch_y     (touch_y),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [READING_W-1:0] frame_reading(input logic [FRAME_W-1:0] f);
    return f[FRAME_W-1] ? READING_MAX : f[FRAME_W-2:3];
  endfunction

  function automatic bit beyond_deviation(input logic [READING_W-1:0] r, anchor);
    return ((r > anchor) ? (r - anchor) : (anchor - r)) > MAX_DEVIATION;
  endfunction

  function automatic touch_point_t calibrated_point(input logic [SUM_W-1:0] sx, sy);
    longint ax, ay, den, cx, cy, px, py;
    touch_point_t p;
    ax = longint'(sx) / AVERAGE_COUNT;
    ay = longint'(sy) / AVERAGE_COUNT;
    den = longint'(cal_div);
    p = '{PIX_NONE, PIX_NONE, STAT_RANGE};
    if (den == 0) return p;
    cx = (longint'(cal_a) * ax + longint'(cal_b) * ay + longint'(cal_c)) / den;
    cy = (longint'(cal_d) * ax + longint'(cal_e) * ay + longint'(cal_f)) / den;
    if (!(cx > 0 && cx < PANEL_WIDTH && cy > 0 && cy < PANEL_HEIGHT)) return p;
    case (cal_orient)
      ORIENT_90: begin
        px = cx;
        py = cy;
      end
      ORIENT_180: begin
        px = cy;
        py = PANEL_HEIGHT - cx;
      end
      ORIENT_270: begin
        px = cx;
        py = PANEL_WIDTH - cy;
      end
      default: begin
        px = PANEL_WIDTH - cy;
        py = cx;
      end
    endcase
    p.x = px[PIX_W-1:0];
    p.y = py[PIX_W-1:0];
    p.status = STAT_VALID;
    return p;
  endfunction

  task automatic clear_collection();
    anchor_first = '0;
    anchor_second = '0;
    acc_first = '0;
    acc_second = '0;
    held_pairs = 0;
  endtask

  task automatic predict_sample(input logic pu, input logic [FRAME_W-1:0] ff, sf);
    logic [READING_W-1:0] rf, rs;
    if (pu) begin
      clear_collection();
      touch_q.push_back('{PIX_NONE, PIX_NONE, STAT_PEN_UP});
      return;
    end
    rf = frame_reading(ff);
    rs = frame_reading(sf);
    if (held_pairs == 0) begin
      anchor_first = rf;
      anchor_second = rs;
      acc_first = '0;
      acc_second = '0;
      held_pairs = 1;
      return;
    end
    if (beyond_deviation(rf, anchor_first) || beyond_deviation(rs, anchor_second)) begin
      clear_collection();
      return;
    end
    acc_first = acc_first + SUM_W'(rf);
    acc_second = acc_second + SUM_W'(rs);
    if (held_pairs >= AVERAGE_COUNT) begin
      touch_q.push_back(calibrated_point(acc_first, acc_second));
      clear_collection();
    end else begin
      held_pairs++;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_sample(input logic pu, input logic [FRAME_W-1:0] ff, sf);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pen_up <= pu;
    first_frame <= ff;
    second_frame <= sf;
    do @(posedge clk); while (in_stall);
    predict_sample(pu, ff, sf);
    items_sent++;
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (touch_q.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ORIENTATION: cal_orient = data[ORIENT_W-1:0];
      REG_COEF_A:      cal_a = data;
      REG_COEF_B:      cal_b = data;
      REG_COEF_C:      cal_c = data;
      REG_COEF_D:      cal_d = data;
      REG_COEF_E:      cal_e = data;
      REG_COEF_F:      cal_f = data;
      default:         cal_div = data;
    endcase
  endtask

  task automatic load_calibration(input logic [ORIENT_W-1:0] orient,
                                  input int a, b, c, d, e, f, div);
    logic [COEF_W-1:0] orient_word;
    wait_results();
    repeat (BLOCK_LATENCY) @(posedge clk);
    orient_word = $urandom;
    orient_word[ORIENT_W-1:0] = orient;
    write_reg(REG_ORIENTATION, orient_word);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
    write_reg(REG_COEF_E, e);
    write_reg(REG_COEF_F, f);
    write_reg(REG_DIVISOR, div);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [FRAME_W-1:0] reading_frame(input int r);
    logic [READING_W-1:0] rd;
    logic [2:0] low;
    if (r == int'(READING_MAX) && $urandom_range(0, 1))
      return FRAME_W'($urandom_range(16'h7FF8, 16'hFFFF));
    rd = READING_W'(r);
    low = 3'($urandom);
    return {1'b0, rd, low};
  endfunction

  function automatic int near_reading(input int b);
    int v;
    v = b + int'($urandom_range(0, 2 * MAX_DEVIATION)) - MAX_DEVIATION;
    if (v < 0) v = 0;
    if (v > int'(READING_MAX)) v = int'(READING_MAX);
    return v;
  endfunction

  function automatic int far_reading(input int b);
    if (b >= 2048) return b - int'($urandom_range(MAX_DEVIATION + 1, b));
    return b + int'($urandom_range(MAX_DEVIATION + 1, int'(READING_MAX) - b));
  endfunction

  // mostly clean touches, some broken by a spike or a lift, some pen-ups and noise
  task automatic run_touches(input int item_budget, input int base_max);
    int stop_at, bx, by, pick, break_at;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (held_pairs != 0) send_sample(1'b1, FRAME_W'($urandom), FRAME_W'($urandom));
        bx = $urandom_range(0, base_max);
        by = $urandom_range(0, base_max);
        break_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, AVERAGE_COUNT) : 0;
        send_sample(1'b0, reading_frame(bx), reading_frame(by));
        for (int k = 1; k <= AVERAGE_COUNT; k++) begin
          if (k == break_at) begin
            case ($urandom_range(0, 2))
              0: send_sample(1'b1, FRAME_W'($urandom), FRAME_W'($urandom));
              1: send_sample(1'b0, reading_frame(far_reading(bx)),
                             reading_frame(near_reading(by)));
              default: send_sample(1'b0, reading_frame(near_reading(bx)),
                                   reading_frame(far_reading(by)));
            endcase
            break;
          end
          send_sample(1'b0, reading_frame(near_reading(bx)), reading_frame(near_reading(by)));
        end
      end else if (pick < 85) begin
        send_sample(1'b1, FRAME_W'($urandom), FRAME_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_sample($urandom_range(0, 7) == 0, FRAME_W'($urandom), FRAME_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_sample(1'b1, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF);
    send_sample(1'b0, 16'h0000, 16'h0007);
    send_sample(1'b0, {1'b0, 12'd1000, 3'b111}, {1'b0, 12'd1000, 3'b000});
    send_sample(1'b0, {1'b0, 12'd1000, 3'b000}, {1'b0, 12'd1101, 3'b000});
    send_sample(1'b0, {1'b0, 12'd1800, 3'b010}, {1'b0, 12'd2300, 3'b101});
    for (int k = 0; k < AVERAGE_COUNT; k++) begin
      if (k % 2 == 0)
        send_sample(1'b0, {1'b0, 12'd1900, 3'b111}, {1'b0, 12'd2200, 3'b000});
      else
        send_sample(1'b0, {1'b0, 12'd1700, 3'b000}, {1'b0, 12'd2400, 3'b111});
    end
    send_sample(1'b0, 16'h7FF8, 16'h8000);
    send_sample(1'b1, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_default_calibration();
    run_touches(200, READING_MAX);
  endtask

  task automatic test_orientation_sweep();
    int sgn;
    for (int o = 0; o < 4; o++) begin
      sgn = (o % 2 == 0) ? 1 : -1;
      load_calibration(ORIENT_W'(o), sgn * PANEL_WIDTH, 0, 0, 0, sgn * PANEL_HEIGHT, 0,
                       sgn * 4096);
      run_touches(180, READING_MAX);
    end
  endtask

  task automatic test_zero_divisor();
    load_calibration(ORIENT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, 0);
    run_touches(100, READING_MAX);
  endtask

  task automatic test_extreme_coefficients();
    load_calibration(ORIENT_270, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    run_touches(60, 100);
    load_calibration(ORIENT_180, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    run_touches(60, 100);
    load_calibration(ORIENT_90, -1, 0, 0, 0, -1, 0, -1);
    run_touches(60, 300);
    load_calibration(ORIENT_0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    run_touches(60, READING_MAX);
  endtask

  task automatic test_random_calibration();
    int den, ka, kb, kc, kd, ke, kf;
    for (int p = 0; p < 4; p++) begin
      if (p == 3) begin
        load_calibration(ORIENT_W'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      end else begin
        den = $urandom_range(1000, 100000);
        if ($urandom_range(0, 1)) den = -den;
        ka = $urandom_range(180, 300);
        kb = int'($urandom_range(0, 40)) - 20;
        kc = int'($urandom_range(0, 60)) - 30;
        kd = int'($urandom_range(0, 40)) - 20;
        ke = $urandom_range(240, 400);
        kf = int'($urandom_range(0, 60)) - 30;
        load_calibration(ORIENT_W'($urandom), den * ka / 4096, den * kb / 4096, den * kc,
                         den * kd / 4096, den * ke / 4096, den * kf, den);
      end
      run_touches(100, READING_MAX);
    end
  endtask

  task automatic test_drain_pause();
    run_touches(20, READING_MAX);
    wait_results();
    run_touches(20, READING_MAX);
  endtask

  task automatic test_back_to_back();
    load_calibration(ORIENT_0, RST_COEF_A, RST_COEF_B, RST_COEF_C,
                     RST_COEF_D, RST_COEF_E, RST_COEF_F, RST_DIVISOR);
    no_gaps = 1'b1;
    run_touches(150, READING_MAX);
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      if (out_valid) rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    touch_point_t want;
    if (out_valid && !out_stall) begin
      rx_hold = no_gaps ? 0 : $urandom_range(0, 3);
      if (touch_q.size() == 0) begin
        $error("unexpected result: touch_x %0d touch_y %0d status %0d",
               touch_x, touch_y, status);
        mismatches++;
      end else begin
        want = touch_q.pop_front();
        if (touch_x !== want.x) begin
          $error("touch_x: expected %0d, got %0d", want.x, touch_x);
          mismatches++;
        end
        if (touch_y !== want.y) begin
          $error("touch_y: expected %0d, got %0d", want.y, touch_y);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[touch_sample_average_calibrate] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = REG_ORIENTATION;
    cfg_data = '0;
    in_valid = 1'b0;
    pen_up = 1'b0;
    first_frame = '0;
    second_frame = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_default_calibration();
    test_orientation_sweep();
    test_zero_divisor();
    test_extreme_coefficients();
    test_random_calibration();
    test_drain_pause();
    test_back_to_back();

    wait_results();
    repeat (BLOCK_LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("[touch_sample_average_calibrate] OK");
    else
      $display("[touch_sample_average_calibrate] ERROR");
    $finish;
  end

endmodule
